[design/bms_pkg.sv]
package bms_pkg;

  localparam int CFG_W   = 10;
  localparam int SHADE_W = 8;
  localparam int POS_W   = 9;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LIGHT_COL    = 2'd2;
  localparam logic [1:0] REG_LIGHT_ROW    = 2'd3;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 10'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd256;
  localparam logic [CFG_W-1:0] LIGHT_COL_RST    = 10'd32;
  localparam logic [CFG_W-1:0] LIGHT_ROW_RST    = 10'd0;
  localparam int               MIN_SIZE         = 3;

  // light map: 16384*k*k >= 65025*d2, centre of the map at 128
  localparam logic [15:0] SHADE_SCALE = 16'd65025;
  localparam int          K_SHIFT     = 14;
  localparam int          K_W         = 9;
  localparam int          MAP_CENTER  = 128;
  localparam int          SHADE_MAX   = 255;

  typedef struct packed {
    logic [7:0]       nx;
    logic [7:0]       ny;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } pix_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_SCALE,
    BK_SEARCH,
    BK_HOLD
  } back_state_t;

endpackage

[design/bms_front.sv]
module bms_front import bms_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [7:0]       height_sample,
  input  logic             in_valid,
  output logic             in_ready,
  input  queue_status_t    queue_stat,
  output logic             push,
  output pix_rec_t         rec
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int MW0 = (CW > RW) ? CW : RW;
  localparam int MW  = (MW0 > CFG_W) ? MW0 : CFG_W;
  localparam int SZW = MW + 1;
  localparam int NW  = MW + 2;

  logic [CFG_W-1:0]        frame_width;
  logic [CFG_W-1:0]        frame_height;
  logic signed [CFG_W-1:0] light_col;
  logic signed [CFG_W-1:0] light_row;

  logic [7:0]    line_buf [MAX_WIDTH];
  logic [7:0]    prev_height;
  logic [7:0]    prev_above;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  logic [SZW-1:0] w_eff, h_eff, c_ext, r_ext;
  logic           accept, emit, row_last, frame_last;
  logic signed [NW-1:0] nx_sum, ny_sum;

  assign in_ready = !queue_stat.full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      light_col    <= LIGHT_COL_RST;
      light_row    <= LIGHT_ROW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_LIGHT_COL:    light_col    <= cfg_data;
        REG_LIGHT_ROW:    light_row    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes clamped to 3..max
  always_comb begin
    if (SZW'(frame_width) < SZW'(MIN_SIZE)) begin
      w_eff = SZW'(MIN_SIZE);
    end else if (SZW'(frame_width) > SZW'(MAX_WIDTH)) begin
      w_eff = SZW'(MAX_WIDTH);
    end else begin
      w_eff = SZW'(frame_width);
    end
    if (SZW'(frame_height) < SZW'(MIN_SIZE)) begin
      h_eff = SZW'(MIN_SIZE);
    end else if (SZW'(frame_height) > SZW'(MAX_HEIGHT)) begin
      h_eff = SZW'(MAX_HEIGHT);
    end else begin
      h_eff = SZW'(frame_height);
    end
  end

  assign c_ext      = SZW'(col_count);
  assign r_ext      = SZW'(row_count);
  assign row_last   = (c_ext + SZW'(1)) >= w_eff;
  assign frame_last = (r_ext + SZW'(1)) >= h_eff;
  assign emit       = (r_ext >= SZW'(1)) && ((r_ext + SZW'(2)) <= h_eff) &&
                      (c_ext >= SZW'(2)) && ((c_ext + SZW'(1)) <= w_eff);

  // light-map coordinates for pixel (c-1, r)
  always_comb begin
    nx_sum = NW'(height_sample) - NW'(prev_height) + NW'(col_count) - NW'(1)
             - NW'(light_col);
    ny_sum = NW'(prev_height) - NW'(prev_above) + NW'(row_count) - NW'(light_row);
    rec.nx = ((nx_sum < 0) || (nx_sum > NW'(SHADE_MAX))) ? 8'd0 : nx_sum[7:0];
    rec.ny = ((ny_sum < 0) || (ny_sum > NW'(SHADE_MAX))) ? 8'd0 : ny_sum[7:0];
    rec.col       = POS_W'(col_count - CW'(1));
    rec.row       = POS_W'(row_count);
    rec.frame_end = ((c_ext + SZW'(1)) == w_eff) && ((r_ext + SZW'(2)) == h_eff);
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (accept) begin
      line_buf[col_count] <= height_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_above  <= '0;
      prev_height <= '0;
      col_count   <= '0;
      row_count   <= '0;
    end else if (accept) begin
      prev_above  <= line_buf[col_count];
      prev_height <= height_sample;
      if (row_last) begin
        col_count <= '0;
        row_count <= frame_last ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_stat.full)
    else $error("pixel pushed into a full queue");

  a_no_emit_on_row_start: assert property (@(posedge clk) disable iff (rst)
    (accept && row_last) |=> !emit)
    else $error("first column of a row treated as interior");

  a_no_emit_on_row_zero: assert property (@(posedge clk) disable iff (rst)
    (row_count == '0) |-> !emit)
    else $error("row zero treated as interior");

endmodule

[design/bms_queue.sv]
module bms_queue import bms_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pix_rec_t      push_rec,
  input  logic          pop,
  output pix_rec_t      head_rec,
  output queue_status_t stat
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  pix_rec_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign stat.full  = count == (PW+1)'(DEPTH);
  assign stat.empty = count == '0;
  assign head_rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("queue count past depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers out of step");

endmodule

[design/bms_back.sv]
module bms_back import bms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  queue_status_t      queue_stat,
  input  pix_rec_t           head_rec,
  output logic               pop,
  output logic [SHADE_W-1:0] shade,
  output logic [POS_W-1:0]   pixel_col,
  output logic [POS_W-1:0]   pixel_row,
  output logic               frame_end,
  output logic               out_valid,
  input  logic               out_ready
);

  back_state_t state, state_next;

  pix_rec_t        cur;
  logic [16:0]     d2;
  logic [31:0]     target;
  logic [K_W-1:0]  k_low;
  logic [K_W-1:0]  mask;

  logic signed [8:0]  dx, dy;
  logic signed [17:0] sq_x, sq_y;
  logic [31:0]        scaled;
  logic [K_W-1:0]     cand;
  logic [2*K_W-1:0]   cand_sq;
  logic [31:0]        probe;
  logic [K_W:0]       k_final;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (!queue_stat.empty) state_next = BK_SQUARE;
      BK_SQUARE: state_next = BK_SCALE;
      BK_SCALE:  state_next = BK_SEARCH;
      BK_SEARCH: if (mask[0]) state_next = BK_HOLD;
      BK_HOLD:   if (out_ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state)
      BK_IDLE: pop       = !queue_stat.empty;
      BK_HOLD: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign dx      = $signed({1'b0, cur.nx}) - 9'(MAP_CENTER);
  assign dy      = $signed({1'b0, cur.ny}) - 9'(MAP_CENTER);
  assign sq_x    = dx * dx;
  assign sq_y    = dy * dy;
  assign scaled  = 32'(d2) * 32'(SHADE_SCALE);
  assign cand    = k_low | mask;
  assign cand_sq = cand * cand;
  assign probe   = 32'({cand_sq, K_SHIFT'(0)});

  // greedy search for the largest k_low with 16384*k_low^2 < target
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!queue_stat.empty) begin
          cur <= head_rec;
        end
      end
      BK_SQUARE: d2 <= 17'(sq_x + sq_y);
      BK_SCALE: begin
        target <= scaled;
        k_low  <= '0;
        mask   <= {1'b1, {(K_W-1){1'b0}}};
      end
      BK_SEARCH: begin
        if (probe < target) begin
          k_low <= cand;
        end
        mask <= mask >> 1;
      end
      default: ;
    endcase
  end

  assign k_final   = (target == '0) ? '0 : ({1'b0, k_low} + (K_W+1)'(1));
  assign shade     = (k_final > (K_W+1)'(SHADE_MAX)) ? '0
                   : SHADE_W'((K_W+1)'(SHADE_MAX) - k_final);
  assign pixel_col = cur.col;
  assign pixel_row = cur.row;
  assign frame_end = cur.frame_end;

  a_search_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEARCH) |-> $onehot(mask))
    else $error("search step mask not one-hot");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == BK_SQUARE))
    else $error("popped item not taken into work");

  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(shade)))
    else $error("result dropped before being taken");

endmodule

[design/bump_map_shader.sv]
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------------
// pixel in | in_valid / in_ready     | height_sample
// shade out| out_valid / out_ready   | shade, pixel_col, pixel_row, frame_end
// config   | cfg_wr_en (no wait)     | cfg_index, cfg_data
//
// the front takes one height item per cycle while the queue has room; border items
// produce nothing and never stall the front beyond that
// each interior item passes through the shading engine as one pop, one square, one
// scale, nine greedy search steps with a 9x9 multiply, and a hold until out_ready
// the engine takes one item at a time and pops another only after its result is taken
// a 2-entry queue between front and back lets input keep flowing while a result waits
// rst is synchronous and active high; the line buffer is not cleared
module bump_map_shader import bms_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  // height-map pixels
  input  logic [7:0]         height_sample,
  input  logic               in_valid,
  output logic               in_ready,
  // shaded pixels
  output logic [SHADE_W-1:0] shade,
  output logic [POS_W-1:0]   pixel_col,
  output logic [POS_W-1:0]   pixel_row,
  output logic               frame_end,
  output logic               out_valid,
  input  logic               out_ready
);

  // front to queue
  logic          push;
  pix_rec_t      push_rec;
  // queue to back
  logic          pop;
  pix_rec_t      head_rec;
  queue_status_t queue_stat;

  // counters, line buffer and coordinate folding
  bms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .height_sample (height_sample),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .queue_stat    (queue_stat),
    .push          (push),
    .rec           (push_rec)
  );

  // decouples pixel intake from the shading engine
  bms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (queue_stat)
  );

  // radial light map: distance squared, scale, integer root search
  bms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_stat (queue_stat),
    .head_rec   (head_rec),
    .pop        (pop),
    .shade      (shade),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  a_pop_only_when_idle_queue_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> !out_valid)
    else $error("new item popped while a result is held");

  a_ready_tracks_room: assert property (@(posedge clk) disable iff (rst)
    in_ready == !queue_stat.full)
    else $error("input ready out of step with queue room");

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && in_ready))
    else $error("item queued without an accepted input");

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bms_pkg::*;

  localparam int MAX_W         = 512;
  localparam int MAX_H         = 512;
  localparam int RANDOM_ITEMS  = 100;
  localparam int TALL_ROWS     = 16;
  // margin for a result to pass the 2-entry queue and the shading engine
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  // one shaded pixel as the block should emit it
  typedef struct {
    logic [SHADE_W-1:0] shade;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               last_pixel;
  } shade_rec_t;

  // receiver stall behavior, picked by the receiver itself
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  // shape of the height data in a random phase
  typedef enum logic [1:0] {
    RELIEF_NOISE,
    RELIEF_SMOOTH,
    RELIEF_CLIFF
  } relief_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic [7:0]         height_sample;
  logic               in_valid;
  logic               in_ready;
  logic [SHADE_W-1:0] shade;
  logic [POS_W-1:0]   pixel_col;
  logic [POS_W-1:0]   pixel_row;
  logic               frame_end;
  logic               out_valid;
  logic               out_ready = 1'b0;

  bump_map_shader #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .height_sample(height_sample),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .shade        (shade),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shader predictor: register copies, line buffer and raster position
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [CFG_W-1:0] light_col_reg;
  logic [CFG_W-1:0] light_row_reg;
  logic [7:0]       line_mem [MAX_W];
  bit               line_loaded [MAX_W];  // entry written at least once since reset
  logic [7:0]       last_height;
  logic [7:0]       above_height;
  int unsigned      cur_col;
  int unsigned      cur_row;

  shade_rec_t shade_expected [$];
  int         mismatches = 0;

  // sender pacing
  int burst_left  = 0;
  bit steady_feed = 1'b0;

  // receiver hold-off requests, served by the receiver process
  int           hold_requests = 0;
  int           holds_served  = 0;
  int           hold_left     = 0;
  int           style_left    = 0;
  stall_style_t stall_style   = STALL_NONE;

  int unsigned cycle_count = 0;

  // sizes below 3 act as 3, above the maximum as the maximum
  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned top);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > top) return top;
    return v;
  endfunction

  // normal coordinates outside the light map fold to zero
  function automatic int fold_coord(int n);
    return (n < 0 || n > 255) ? 0 : n;
  endfunction

  function automatic void reset_predictor();
    width_reg     = FRAME_WIDTH_RST;
    height_reg    = FRAME_HEIGHT_RST;
    light_col_reg = LIGHT_COL_RST;
    light_row_reg = LIGHT_ROW_RST;
    foreach (line_mem[j]) begin
      line_mem[j]    = 8'd0;
      line_loaded[j] = 1'b0;
    end
    last_height  = 8'd0;
    above_height = 8'd0;
    cur_col      = 0;
    cur_row      = 0;
  endfunction

  // one accepted height item: emit for the interior pixel to its left, then advance
  function automatic void predict_pixel(logic [7:0] h);
    int unsigned     w, ht, c, r;
    int              x, y, u, v, nx, ny;
    longint unsigned dist2, target;
    int              k;
    shade_rec_t      rec;
    w  = clamp_size(width_reg, MAX_W);
    ht = clamp_size(height_reg, MAX_H);
    c  = cur_col;
    r  = cur_row;
    if (r >= 1 && r + 2 <= ht && c >= 2 && c + 1 <= w) begin
      x  = c - 1;
      y  = r;
      u  = int'(h) - int'(last_height);
      v  = int'(last_height) - int'(above_height);
      nx = fold_coord(u + x - int'($signed(light_col_reg)));
      ny = fold_coord(v + y - int'($signed(light_row_reg)));
      dist2 = longint'((nx - MAP_CENTER) * (nx - MAP_CENTER) +
                       (ny - MAP_CENTER) * (ny - MAP_CENTER));
      target = 64'd65025 * dist2;
      // least k with 16384*k*k >= 65025*d2, shade clamps at zero
      k = 0;
      while (k <= SHADE_MAX && (64'd16384 * k * k) < target) k++;
      rec.shade      = (k > SHADE_MAX) ? 8'd0 : 8'(SHADE_MAX - k);
      rec.col        = POS_W'(x);
      rec.row        = POS_W'(y);
      rec.last_pixel = (c + 1 == w && r + 2 == ht);
      shade_expected.push_back(rec);
    end
    above_height   = line_mem[c];
    line_mem[c]    = h;
    line_loaded[c] = 1'b1;
    last_height    = h;
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= ht) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offer one height item, hold it until taken, then maybe pause between bursts
  task automatic push_height(input logic [7:0] h);
    int gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    height_sample <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(h);
    burst_left--;
    if (!steady_feed && burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // stop offering, wait for every pending shade, then let the engine go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shade_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_reg     = val;
      REG_FRAME_HEIGHT: height_reg    = val;
      REG_LIGHT_COL:    light_col_reg = val;
      REG_LIGHT_ROW:    light_row_reg = val;
      default: ;
    endcase
  endtask

  // a wider frame may only be set where no never-written line entry can be read:
  // on row 0 the entries get written before use, elsewhere all must be loaded
  task automatic set_width(input logic [CFG_W-1:0] val);
    int unsigned w;
    bit          ok;
    w  = clamp_size(val, MAX_W);
    ok = 1'b1;
    if (cur_row != 0) begin
      for (int j = 0; j < w; j++) begin
        if (!line_loaded[j]) ok = 1'b0;
      end
    end
    if (ok) write_reg(REG_FRAME_WIDTH, val);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    set_width(w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // mostly small frames, sometimes below the minimum, sometimes large
  function automatic logic [CFG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return CFG_W'($urandom_range(3, 16));
    if (roll < 16) return CFG_W'($urandom_range(17, 64));
    if (roll < 18) return CFG_W'($urandom_range(0, 2));
    return CFG_W'($urandom_range(65, 1023));
  endfunction

  // light near the middle of the frame keeps normals on the map, else anywhere
  function automatic logic [CFG_W-1:0] pick_light(int unsigned span);
    if ($urandom_range(0, 2) == 0) return CFG_W'($urandom_range(0, 1023));
    return CFG_W'(int'(span / 2) - MAP_CENTER + int'($urandom_range(0, 40)) - 20);
  endfunction

  // shrink to 3x3 and run to the start of a frame
  task automatic align_frame();
    settle();
    set_frame(10'd3, 10'd3);
    while (cur_col != 0 || cur_row != 0) push_height(8'($urandom_range(0, 255)));
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry 320x256 and light (32,0): first row plus a bit of the next
  task automatic test_reset_values();
    for (int j = 0; j < 330; j++) push_height((j % 2) ? 8'd200 : 8'd20);
  endtask

  // flat 4x4 frame with the light over interior pixel (2,1): full shade there
  task automatic test_flat_center();
    align_frame();
    set_frame(10'd4, 10'd4);
    write_reg(REG_LIGHT_COL, CFG_W'(-126));
    write_reg(REG_LIGHT_ROW, CFG_W'(-127));
    repeat (16) push_height(8'd100);
  endtask

  // 3x3 frame, steepest slopes and extreme light: both coordinates fold to zero
  task automatic test_fold_to_zero();
    logic [7:0] cliff [9] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
    settle();
    set_frame(10'd3, 10'd3);
    write_reg(REG_LIGHT_COL, 10'h200);
    write_reg(REG_LIGHT_ROW, 10'h1ff);
    foreach (cliff[j]) push_height(cliff[j]);
  endtask

  // widest frame (width written past the maximum, height below the minimum)
  // up to its last interior pixel, then a few rows of a frame written taller
  // than the maximum
  task automatic test_size_extremes();
    settle();
    set_frame(10'd1023, 10'd2);
    write_reg(REG_LIGHT_COL, CFG_W'(128));
    write_reg(REG_LIGHT_ROW, CFG_W'(-127));
    repeat (2 * MAX_W) push_height(8'($urandom_range(0, 255)));
    settle();
    set_frame(10'd3, 10'd1023);
    write_reg(REG_LIGHT_COL, CFG_W'(-127));
    write_reg(REG_LIGHT_ROW, CFG_W'(128));
    repeat (3 * TALL_ROWS) push_height(8'($urandom_range(0, 255)));
  endtask

  // shrink the frame while the position lies past the new size: counters wrap
  task automatic test_midframe_resize();
    settle();
    set_frame(10'd10, 10'd10);
    write_reg(REG_LIGHT_COL, CFG_W'(-123));
    write_reg(REG_LIGHT_ROW, CFG_W'(-123));
    repeat (57) push_height(8'($urandom_range(0, 255)));
    settle();
    set_frame(10'd4, 10'd3);
    repeat (30) push_height(8'($urandom_range(0, 255)));
  endtask

  // receiver holds off for a long stretch while items keep coming back to back
  task automatic test_input_stall();
    settle();
    set_frame(10'd6, 10'd6);
    steady_feed = 1'b1;
    hold_requests++;
    repeat (150) push_height(8'($urandom_range(0, 255)));
    steady_feed = 1'b0;
  endtask

  // phases of random geometry, light and relief, split at arbitrary positions
  task automatic test_random_frames();
    int         sent, n;
    relief_t    relief;
    logic [7:0] h;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 1)) set_width(pick_size());
      if ($urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, pick_size());
      if ($urandom_range(0, 1))
        write_reg(REG_LIGHT_COL, pick_light(clamp_size(width_reg, MAX_W)));
      if ($urandom_range(0, 1))
        write_reg(REG_LIGHT_ROW, pick_light(clamp_size(height_reg, MAX_H)));
      steady_feed = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) hold_requests++;
      relief = relief_t'($urandom_range(0, 2));
      n = $urandom_range(20, 200);
      repeat (n) begin
        case (relief)
          RELIEF_SMOOTH: h = 8'(int'(last_height) + int'($urandom_range(0, 16)) - 8);
          RELIEF_CLIFF:  h = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          default:       h = 8'($urandom_range(0, 255));
        endcase
        push_height(h);
      end
      sent += n;
    end
    steady_feed = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern re-picked when its random span runs out, hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (style_left <= 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        style_left  = $urandom_range(16, 128);
      end
      style_left--;
      case (stall_style)
        STALL_NONE:  out_ready <= 1'b1;
        STALL_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= ((style_left % 8) < 5);
      endcase
    end
  end

  // compare each taken result against the oldest pending shade
  always @(posedge clk) begin : check_results
    shade_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (shade_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected shade %0d at col %0d row %0d end %0b",
                   shade, pixel_col, pixel_row, frame_end);
      end else begin
        want = shade_expected.pop_front();
        if (shade !== want.shade || pixel_col !== want.col ||
            pixel_row !== want.row || frame_end !== want.last_pixel) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected shade %0d col %0d row %0d end %0b, got %0d %0d %0d %0b",
                     want.shade, want.col, want.row, want.last_pixel,
                     shade, pixel_col, pixel_row, frame_end);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_FRAME_WIDTH;
    cfg_data      = '0;
    height_sample = 8'd0;
    in_valid      = 1'b0;
    reset_predictor();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_flat_center();
    test_fold_to_zero();
    test_size_extremes();
    test_midframe_resize();
    test_input_stall();
    test_random_frames();

    // drain and let the engine finish
    settle();
    if (shade_expected.size() != 0)
      $display("%0d shaded pixels never arrived", shade_expected.size());
    if (mismatches == 0 && shade_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
